// File: hdl/nclx_pkg.sv
// Package for the nested comment lexer: lexer modes, status codes, state types.
package nclx_pkg;

  localparam int DelimMaxDefault = 32;
  localparam int DepthMaxDefault = 255;

  localparam logic [4:0] M_IDLE         = 5'd0;
  localparam logic [4:0] M_WS_ALLOW     = 5'd1;
  localparam logic [4:0] M_WS_DENY      = 5'd2;
  localparam logic [4:0] M_OPEN_STAR    = 5'd3;
  localparam logic [4:0] M_BODY         = 5'd4;
  localparam logic [4:0] M_IDENT        = 5'd5;
  localparam logic [4:0] M_AFTER_LPAREN = 5'd6;
  localparam logic [4:0] M_AFTER_STAR   = 5'd7;
  localparam logic [4:0] M_STRING       = 5'd8;
  localparam logic [4:0] M_STRING_ESC   = 5'd9;
  localparam logic [4:0] M_CHAR_START   = 5'd10;
  localparam logic [4:0] M_CHAR_ESC     = 5'd11;
  localparam logic [4:0] M_CHAR_DEC     = 5'd12;
  localparam logic [4:0] M_CHAR_HEX     = 5'd13;
  localparam logic [4:0] M_CHAR_OCT     = 5'd14;
  localparam logic [4:0] M_CHAR_CLOSE   = 5'd15;
  localparam logic [4:0] M_QID          = 5'd16;
  localparam logic [4:0] M_QBODY        = 5'd17;
  localparam logic [4:0] M_QMATCH       = 5'd18;

  localparam logic [2:0] ST_SKIP     = 3'd0;
  localparam logic [2:0] ST_CONSUME  = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_REJECT   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam int DispatchStages = 5;

  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] depth;
    logic [7:0] held;
    logic [5:0] dlen;
    logic [5:0] mpos;
    logic [1:0] esc;
  } nclx_state_t;

endpackage

// File: hdl/nclx_if.sv
// Valid/ready channel interfaces for the lexer input and result beats.
interface nclx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_end;
  logic       start_req;
  logic       comment_allowed;
  modport source (output valid, in_byte, at_end, start_req, comment_allowed, input ready);
  modport sink (input valid, in_byte, at_end, start_req, comment_allowed, output ready);
endinterface

interface nclx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] nest_depth;
  modport source (output valid, status, nest_depth, input ready);
  modport sink (input valid, status, nest_depth, output ready);
endinterface

// File: hdl/nested_comment_lexer_core.sv
// Top level of the nested comment lexer: state registers, delimiter RAM, result register.
// A result beat is registered in the cycle after its input beat is accepted.
// One byte per cycle unless out_ch stalls; all re-dispatches resolve in the same cycle.
// The delimiter store is a registered-read RAM addressed with the next match position.
// Reset (synchronous, rst_n low) makes the lexer idle with all counters cleared;
// the delimiter RAM is not cleared and needs no clearing pass.
module nested_comment_lexer_core import nclx_pkg::*; #(
  parameter int DELIM_MAX = DelimMaxDefault,
  parameter int DEPTH_MAX = DepthMaxDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  nclx_in_if.sink     in_ch,
  nclx_out_if.source  out_ch
);
  localparam int Aw = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;
  localparam int Ns = DispatchStages;

  nclx_state_t st_r, st_nxt, st_start;
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  depth_r;
  logic        accept;

  nclx_state_t    chain_st [Ns+1];
  logic [Ns:0]    live;
  logic [Ns-1:0]  again_v, we_v;
  logic [2:0]     stat_v [Ns];
  logic [Aw-1:0]  waddr_v [Ns];
  logic [7:0]     dl_rdata;
  logic           dl_we;
  logic [Aw-1:0]  dl_waddr;
  logic [Aw-1:0]  dl_raddr;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    st_start = st_r;
    if (in_ch.start_req) begin
      st_start = '0;
      st_start.mode = in_ch.comment_allowed ? M_WS_ALLOW : M_WS_DENY;
    end
  end

  assign chain_st[0] = st_start;
  assign live[0] = (st_start.mode != M_IDLE) && !in_ch.at_end;

  for (genvar i = 0; i < Ns; i++) begin : g_disp
    nclx_disp #(.DelimMax(DELIM_MAX), .DepthMax(DEPTH_MAX)) u_disp (
      .st_i     (chain_st[i]),
      .c        (in_ch.in_byte),
      .dl_rdata (dl_rdata),
      .st_o     (chain_st[i+1]),
      .again    (again_v[i]),
      .status   (stat_v[i]),
      .we       (we_v[i]),
      .waddr    (waddr_v[i])
    );
    assign live[i+1] = live[i] && again_v[i];
  end

  always_comb begin
    st_nxt     = st_start;
    status_nxt = ST_REJECT;
    dl_we      = 1'b0;
    dl_waddr   = '0;
    if (st_start.mode == M_IDLE) begin
      status_nxt = ST_REJECT;
    end else if (in_ch.at_end) begin
      st_nxt.mode = M_IDLE;
      status_nxt = ST_REJECT;
    end else begin
      for (int i = Ns - 1; i >= 0; i--) begin
        if (live[i] && !again_v[i]) begin
          st_nxt = chain_st[i+1];
          status_nxt = stat_v[i];
        end
        if (live[i] && we_v[i]) begin
          dl_we = 1'b1;
          dl_waddr = waddr_v[i];
        end
      end
    end
  end

  // Keep the read address on the current match position while stalled.
  assign dl_raddr = accept ? st_nxt.mpos[Aw-1:0] : st_r.mpos[Aw-1:0];

  nclx_ram #(.Width(8), .Depth(DELIM_MAX)) u_delim (
    .clk   (clk),
    .we    (dl_we && accept),
    .waddr (dl_waddr),
    .wdata (in_ch.in_byte),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      depth_r  <= st_nxt.depth;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.nest_depth = depth_r;
endmodule

// File: hdl/nclx_ram.sv
// Generic single-port-write, registered-read RAM.
module nclx_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [Aw-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [Aw-1:0]    raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/nclx_disp.sv
// One dispatch of a byte against the lexer state.
module nclx_disp import nclx_pkg::*; #(
  parameter int DelimMax = DelimMaxDefault,
  parameter int DepthMax = DepthMaxDefault,
  localparam int Aw = (DelimMax > 1) ? $clog2(DelimMax) : 1
) (
  input  nclx_state_t   st_i,
  input  logic [7:0]    c,
  input  logic [7:0]    dl_rdata,
  output nclx_state_t   st_o,
  output logic          again,
  output logic [2:0]    status,
  output logic          we,
  output logic [Aw-1:0] waddr
);
  localparam logic [7:0] DepthLim = 8'(DepthMax);
  localparam logic [5:0] DelimLim = 6'(DelimMax);

  logic is_space, is_digit, is_lower, is_alpha, is_hex, is_oct;
  logic [7:0] key;
  logic       took;

  assign is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_lower = (c >= "a") && (c <= "z");
  assign is_alpha = is_lower || ((c >= "A") && (c <= "Z"));
  assign is_hex   = is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  assign is_oct   = (c >= "0") && (c <= "7");

  always_comb begin
    logic dok;
    st_o   = st_i;
    again  = 1'b0;
    status = ST_CONSUME;
    we     = 1'b0;
    waddr  = st_i.dlen[Aw-1:0];
    key    = c;
    took   = 1'b1;
    dok    = 1'b0;
    case (st_i.mode)
      M_WS_ALLOW, M_WS_DENY: begin
        if (is_space) begin
          status = ST_SKIP;
        end else if (c == "(" && st_i.mode == M_WS_ALLOW) begin
          st_o.mode = M_OPEN_STAR;
        end else begin
          st_o.mode = M_IDLE;
          status = ST_REJECT;
        end
      end
      M_OPEN_STAR: begin
        if (c == "*") begin
          st_o.depth = 8'd1;
          st_o.mode = M_BODY;
        end else begin
          st_o.mode = M_IDLE;
          status = ST_REJECT;
        end
      end
      M_BODY: begin
        if (st_i.held != 8'd0) begin
          key = st_i.held;
          st_o.held = 8'd0;
          took = 1'b0;
        end
        case (key)
          "(":  st_o.mode = M_AFTER_LPAREN;
          "*":  st_o.mode = M_AFTER_STAR;
          "'":  st_o.mode = M_CHAR_START;
          "\"": st_o.mode = M_STRING;
          "{": begin
            st_o.dlen = 6'd0;
            st_o.mode = M_QID;
          end
          default: st_o.mode = (took && (is_alpha || c == "_")) ? M_IDENT : M_BODY;
        endcase
        again = !took;
      end
      M_IDENT: begin
        if (!(is_alpha || is_digit || c == "_" || c == "'")) begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end
      end
      M_AFTER_LPAREN: begin
        if (c == "*") begin
          if (st_i.depth >= DepthLim) begin
            st_o.mode = M_IDLE;
            status = ST_OVERFLOW;
          end else begin
            st_o.depth = st_i.depth + 8'd1;
            st_o.mode = M_BODY;
          end
        end else begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end
      end
      M_AFTER_STAR: begin
        if (c == ")") begin
          if (st_i.depth <= 8'd1) begin
            st_o.depth = 8'd0;
            st_o.mode = M_IDLE;
            status = ST_COMPLETE;
          end else begin
            st_o.depth = st_i.depth - 8'd1;
            st_o.mode = M_BODY;
          end
        end else begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end
      end
      M_STRING: begin
        if (c == "\\") st_o.mode = M_STRING_ESC;
        else if (c == "\"") st_o.mode = M_BODY;
      end
      M_STRING_ESC: st_o.mode = M_STRING;
      M_CHAR_START: begin
        if (c == "\\") begin
          st_o.mode = M_CHAR_ESC;
        end else if (c == "'") begin
          st_o.mode = M_BODY;
        end else if (c == 8'd0) begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end else begin
          st_o.held = c;
          st_o.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (is_digit) begin
          st_o.esc = 2'd2;
          st_o.mode = M_CHAR_DEC;
        end else if (c == "x") begin
          st_o.esc = 2'd2;
          st_o.mode = M_CHAR_HEX;
        end else if (c == "o") begin
          st_o.esc = 2'd3;
          st_o.mode = M_CHAR_OCT;
        end else if (c == "'" || c == "\"" || c == "\\" || c == "n" || c == "t" ||
                     c == "b" || c == "r" || c == " ") begin
          st_o.held = c;
          st_o.mode = M_CHAR_CLOSE;
        end else begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end
      end
      M_CHAR_DEC, M_CHAR_HEX, M_CHAR_OCT: begin
        dok = (st_i.mode == M_CHAR_DEC) ? is_digit :
              (st_i.mode == M_CHAR_HEX) ? is_hex : is_oct;
        if (!dok) begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end else if (st_i.esc <= 2'd1) begin
          st_o.esc = 2'd0;
          st_o.mode = M_CHAR_CLOSE;
        end else begin
          st_o.esc = st_i.esc - 2'd1;
        end
      end
      M_CHAR_CLOSE: begin
        st_o.mode = M_BODY;
        if (c == "'") st_o.held = 8'd0;
        else again = 1'b1;
      end
      M_QID: begin
        if (is_lower || c == "_") begin
          if (st_i.dlen >= DelimLim) begin
            st_o.mode = M_IDLE;
            status = ST_OVERFLOW;
          end else begin
            we = 1'b1;
            st_o.dlen = st_i.dlen + 6'd1;
          end
        end else if (c == "|") begin
          st_o.mode = M_QBODY;
        end else begin
          st_o.mode = M_BODY;
          again = 1'b1;
        end
      end
      M_QBODY: begin
        if (c == "|") begin
          st_o.mpos = 6'd0;
          st_o.mode = M_QMATCH;
        end
      end
      M_QMATCH: begin
        // The stored delimiter byte for mpos was read when the previous byte was accepted.
        if (st_i.mpos < st_i.dlen && st_i.mpos < DelimLim && c == dl_rdata) begin
          st_o.mpos = st_i.mpos + 6'd1;
        end else if (st_i.mpos >= st_i.dlen && c == "}") begin
          st_o.mode = M_BODY;
        end else begin
          st_o.mode = M_QBODY;
          again = 1'b1;
        end
      end
      default: begin
        st_o.mode = M_IDLE;
        status = ST_REJECT;
      end
    endcase
  end
endmodule
